// ===== design/bmp24sd_pkg.sv =====
// shared types, constants and helpers for the 24 bpp bmp stream decoder
// no dependencies
`default_nettype none

package bmp24sd_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int DIM_W        = 13;
  localparam int POS_W        = 32;
  localparam int INDEX_W      = 24;
  localparam int HEADER_BYTES = 54;

  // header byte positions at which a field is complete
  localparam logic [5:0] POS_SIG0     = 6'd0;
  localparam logic [5:0] POS_SIG1     = 6'd1;
  localparam logic [5:0] POS_SIZE     = 6'd5;
  localparam logic [5:0] POS_RESV     = 6'd9;
  localparam logic [5:0] POS_OFFSET   = 6'd13;
  localparam logic [5:0] POS_INFOHDR  = 6'd17;
  localparam logic [5:0] POS_WIDTH    = 6'd21;
  localparam logic [5:0] POS_HEIGHT   = 6'd25;
  localparam logic [5:0] POS_BPP      = 6'd29;
  localparam logic [5:0] POS_COMPRESS = 6'd33;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4d;
  localparam logic [31:0] INFOHDR_SIZE = 32'd40;
  localparam logic [15:0] BPP_24       = 16'd24;
  localparam logic [7:0]  ALPHA        = 8'hff;

  typedef enum logic [3:0] {
    ST_OK,
    ST_SIGNATURE,
    ST_SIZE,
    ST_RESERVED,
    ST_INFOHDR,
    ST_BPP,
    ST_COMPRESSED,
    ST_DIMS,
    ST_OFFSET,
    ST_TRUNCATED
  } status_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [31:0]        pixel_value;
    logic [INDEX_W-1:0] pixel_index;
    logic               done_res;
    status_t            status;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } result_t;

  // keeps the smallest fault code seen so far
  function automatic status_t note_error(status_t cur, status_t code);
    return (cur == ST_OK || code < cur) ? code : cur;
  endfunction

  function automatic logic dim_bad(logic [31:0] v);
    return v[31] || (v == 32'd0) || (v > 32'(MAX_DIM));
  endfunction

endpackage

`default_nettype wire

// ===== design/bmp24_stream_decoder_unit.sv =====
// bmp24 stream decoder top level: header check, pixel unpacking, output buffer
// depends on bmp24sd_pkg
`default_nettype none

// Takes one byte of a 24 bpp uncompressed BMP file per cycle while in_stall
// is low, with no gaps needed between bytes. Each byte updates the header and
// pixel counters in a single registered pass; a result (a finished ARGB pixel
// with its top-down index, and/or done with status and dimensions on the byte
// flagged last) is registered into the output buffer when its byte is taken.
// A two-entry output buffer can hold one more result while the output is
// stalled; in_stall is raised only when both entries are full. After the last
// byte the decoder is back in its reset state and the next byte starts a new
// file.
module bmp24_stream_decoder_unit
  import bmp24sd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    pixel_valid,
  output logic [31:0]             pixel_value,
  output logic [INDEX_W-1:0]      pixel_index,
  output logic                    done_res,
  output logic [3:0]              status,
  output logic [DIM_W-1:0]        image_width,
  output logic [DIM_W-1:0]        image_height
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]      header_shift, header_shift_next;
  logic [31:0]      declared_size, declared_size_next;
  logic [31:0]      pixel_start, pixel_start_next;
  logic [DIM_W-1:0] held_width, held_width_next;
  logic [DIM_W-1:0] held_height, held_height_next;
  status_t          error_code, error_code_next;
  logic [15:0]      channel_hold, channel_hold_next;
  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic [1:0]       padding_left, padding_left_next;
  logic [1:0]       channel_phase, channel_phase_next;

  result_t out_buf, skid_buf, res;
  logic    skid_valid;
  logic    accept, produce, take;

  assign accept  = in_valid && !in_stall;
  assign take    = out_valid && !out_stall;
  assign produce = accept && (res.pixel_valid || res.done_res);

  always_comb begin
    logic [5:0]         pos_lo;
    logic [DIM_W-1:0]   rows_left;
    logic [DIM_W-1:0]   col_inc;
    logic [2*DIM_W-1:0] prod;
    logic               size_bad;
    status_t            st;

    byte_position_next = byte_position;
    header_shift_next  = header_shift;
    declared_size_next = declared_size;
    pixel_start_next   = pixel_start;
    held_width_next    = held_width;
    held_height_next   = held_height;
    error_code_next    = error_code;
    channel_hold_next  = channel_hold;
    column_count_next  = column_count;
    row_count_next     = row_count;
    padding_left_next  = padding_left;
    channel_phase_next = channel_phase;

    pos_lo    = byte_position[5:0];
    rows_left = held_height - DIM_W'(1) - row_count;
    col_inc   = column_count + DIM_W'(1);
    prod      = {{DIM_W{1'b0}}, rows_left} * {{DIM_W{1'b0}}, held_width};
    size_bad  = 1'b0;
    st        = ST_OK;

    res              = '0;
    res.pixel_index  = prod[INDEX_W-1:0] + INDEX_W'(column_count);
    res.pixel_value  = {ALPHA, data_byte, channel_hold};

    if (byte_position < POS_W'(HEADER_BYTES)) begin
      header_shift_next = {data_byte, header_shift[31:8]};
      unique case (pos_lo)
        POS_SIG0: begin
          if (data_byte != SIG_B) error_code_next = note_error(error_code, ST_SIGNATURE);
        end
        POS_SIG1: begin
          if (data_byte != SIG_M) error_code_next = note_error(error_code, ST_SIGNATURE);
        end
        POS_SIZE: declared_size_next = header_shift_next;
        POS_RESV: begin
          if (header_shift_next != 32'd0)
            error_code_next = note_error(error_code, ST_RESERVED);
        end
        POS_OFFSET: begin
          pixel_start_next = header_shift_next;
          if (header_shift_next < 32'(HEADER_BYTES))
            error_code_next = note_error(error_code, ST_OFFSET);
        end
        POS_INFOHDR: begin
          if (header_shift_next != INFOHDR_SIZE)
            error_code_next = note_error(error_code, ST_INFOHDR);
        end
        POS_WIDTH: begin
          if (dim_bad(header_shift_next)) begin
            error_code_next = note_error(error_code, ST_DIMS);
            held_width_next = '0;
          end else begin
            held_width_next = header_shift_next[DIM_W-1:0];
          end
        end
        POS_HEIGHT: begin
          if (dim_bad(header_shift_next)) begin
            error_code_next  = note_error(error_code, ST_DIMS);
            held_height_next = '0;
          end else begin
            held_height_next = header_shift_next[DIM_W-1:0];
          end
        end
        POS_BPP: begin
          if (header_shift_next[31:16] != BPP_24)
            error_code_next = note_error(error_code, ST_BPP);
        end
        POS_COMPRESS: begin
          if (header_shift_next != 32'd0)
            error_code_next = note_error(error_code, ST_COMPRESSED);
        end
        default: begin
        end
      endcase
    end else if (error_code == ST_OK && byte_position >= pixel_start &&
                 row_count < held_height) begin
      if (padding_left != 2'd0) begin
        padding_left_next = padding_left - 2'd1;
      end else if (channel_phase == 2'd0) begin
        channel_hold_next  = {channel_hold[15:8], data_byte};
        channel_phase_next = 2'd1;
      end else if (channel_phase == 2'd1) begin
        channel_hold_next  = {data_byte, channel_hold[7:0]};
        channel_phase_next = 2'd2;
      end else begin
        res.pixel_valid    = 1'b1;
        channel_phase_next = 2'd0;
        if (col_inc >= held_width) begin
          column_count_next = '0;
          row_count_next    = row_count + DIM_W'(1);
          padding_left_next = held_width[1:0];
        end else begin
          column_count_next = col_inc;
        end
      end
    end

    if (!res.pixel_valid) begin
      res.pixel_value = '0;
      res.pixel_index = '0;
    end

    if (byte_position != {POS_W{1'b1}}) byte_position_next = byte_position + POS_W'(1);

    if (last_byte) begin
      st       = error_code_next;
      size_bad = (byte_position >= POS_W'(5)) &&
                 ({1'b0, declared_size_next} != ({1'b0, byte_position} + 33'd1));
      if (size_bad && (st == ST_OK || st > ST_SIZE)) st = ST_SIZE;
      if (st == ST_OK && (byte_position < POS_W'(HEADER_BYTES - 1) ||
                          row_count_next < held_height_next))
        st = ST_TRUNCATED;
      res.done_res     = 1'b1;
      res.status       = st;
      res.image_width  = held_width_next;
      res.image_height = held_height_next;

      byte_position_next = '0;
      header_shift_next  = '0;
      declared_size_next = '0;
      pixel_start_next   = '0;
      held_width_next    = '0;
      held_height_next   = '0;
      error_code_next    = ST_OK;
      channel_hold_next  = '0;
      column_count_next  = '0;
      row_count_next     = '0;
      padding_left_next  = '0;
      channel_phase_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_shift  <= '0;
      declared_size <= '0;
      pixel_start   <= '0;
      held_width    <= '0;
      held_height   <= '0;
      error_code    <= ST_OK;
      channel_hold  <= '0;
      column_count  <= '0;
      row_count     <= '0;
      padding_left  <= '0;
      channel_phase <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      header_shift  <= header_shift_next;
      declared_size <= declared_size_next;
      pixel_start   <= pixel_start_next;
      held_width    <= held_width_next;
      held_height   <= held_height_next;
      error_code    <= error_code_next;
      channel_hold  <= channel_hold_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      padding_left  <= padding_left_next;
      channel_phase <= channel_phase_next;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) out_buf <= skid_buf;
      else if (produce) out_buf <= res;
    end else if (produce) begin
      skid_buf <= res;
    end
  end

  assign in_stall     = skid_valid;
  assign pixel_valid  = out_buf.pixel_valid;
  assign pixel_value  = out_buf.pixel_value;
  assign pixel_index  = out_buf.pixel_index;
  assign done_res     = out_buf.done_res;
  assign status       = out_buf.status;
  assign image_width  = out_buf.image_width;
  assign image_height = out_buf.image_height;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_valid) |-> (pixel_value[31:24] == ALPHA))
    else $error("pixel without opaque alpha");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (status == 4'(ST_OK)))
    else $error("status set on a non-final transaction");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_valid || done_res))
    else $error("empty result transaction");

endmodule

`default_nettype wire

// ===== test/bmp24_stream_decoder_unit_tb.sv =====
// self-checking bench for bmp24_stream_decoder_unit: sends bmp files (whole, faulty, cut short) and noise byte by byte
// and checks every pixel and done result against an in-bench decoder model
// depends on bmp24sd_pkg and bmp24_stream_decoder_unit
module bmp24_stream_decoder_unit_tb;
  import bmp24sd_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BYTES = 300;
  localparam int MAX_REPORTS  = 50;

  // header byte offsets used when building files
  localparam int OFS_SIZE     = 2;
  localparam int OFS_RESV     = 6;
  localparam int OFS_OFFSET   = 10;
  localparam int OFS_INFOHDR  = 14;
  localparam int OFS_WIDTH    = 18;
  localparam int OFS_HEIGHT   = 22;
  localparam int OFS_BPP      = 28;
  localparam int OFS_COMPRESS = 30;

  typedef enum int {F_SIG, F_SIZE, F_RESV, F_INFO, F_BPP, F_COMP, F_OFFSET, F_COUNT} hdr_fault_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               pixel_valid;
  logic [31:0]        pixel_value;
  logic [INDEX_W-1:0] pixel_index;
  logic               done_res;
  logic [3:0]         status;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;

  bmp24_stream_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_valid  (pixel_valid),
    .pixel_value  (pixel_value),
    .pixel_index  (pixel_index),
    .done_res     (done_res),
    .status       (status),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // decoder model state
  logic [31:0]      byte_cnt;
  logic [31:0]      field_shift;
  logic [31:0]      size_field;
  logic [31:0]      pix_offset;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  status_t          fault_q;
  logic [15:0]      bg_hold;
  logic [DIM_W-1:0] col_q;
  logic [DIM_W-1:0] row_q;
  logic [1:0]       pad_q;
  logic [1:0]       phase_q;

  result_t    decoded_q[$];
  logic [7:0] file_bytes[$];

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int fail_cnt = 0;
  int n_files = 0;
  int n_bytes = 0;
  int n_pixels = 0;
  int n_done = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_decoder();
    byte_cnt    = '0;
    field_shift = '0;
    size_field  = '0;
    pix_offset  = '0;
    width_q     = '0;
    height_q    = '0;
    fault_q     = ST_OK;
    bg_hold     = '0;
    col_q       = '0;
    row_q       = '0;
    pad_q       = '0;
    phase_q     = '0;
  endfunction

  // smallest fault code wins
  function automatic void raise_fault(status_t code);
    if (fault_q == ST_OK || code < fault_q) fault_q = code;
  endfunction

  function automatic logic [DIM_W-1:0] take_dim(logic [31:0] v);
    if (v[31] || v == 32'd0 || v > MAX_DIM) begin
      raise_fault(ST_DIMS);
      return '0;
    end
    return v[DIM_W-1:0];
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    result_t     r;
    logic [31:0] idx;
    logic [31:0] last_pos;
    status_t     st;
    logic        pix;
    r   = '0;
    pix = 1'b0;
    if (byte_cnt < HEADER_BYTES) begin
      field_shift = {b, field_shift[31:8]};
      case (byte_cnt[5:0])
        POS_SIG0:     if (b != SIG_B) raise_fault(ST_SIGNATURE);
        POS_SIG1:     if (b != SIG_M) raise_fault(ST_SIGNATURE);
        POS_SIZE:     size_field = field_shift;
        POS_RESV:     if (field_shift != 32'd0) raise_fault(ST_RESERVED);
        POS_OFFSET: begin
          pix_offset = field_shift;
          if (field_shift < HEADER_BYTES) raise_fault(ST_OFFSET);
        end
        POS_INFOHDR:  if (field_shift != INFOHDR_SIZE) raise_fault(ST_INFOHDR);
        POS_WIDTH:    width_q = take_dim(field_shift);
        POS_HEIGHT:   height_q = take_dim(field_shift);
        POS_BPP:      if (field_shift[31:16] != BPP_24) raise_fault(ST_BPP);
        POS_COMPRESS: if (field_shift != 32'd0) raise_fault(ST_COMPRESSED);
        default: ;
      endcase
    end else if (fault_q == ST_OK && byte_cnt >= pix_offset && row_q < height_q) begin
      if (pad_q != 2'd0) begin
        pad_q = pad_q - 2'd1;
      end else if (phase_q == 2'd0) begin
        bg_hold[7:0] = b;
        phase_q      = 2'd1;
      end else if (phase_q == 2'd1) begin
        bg_hold[15:8] = b;
        phase_q       = 2'd2;
      end else begin
        pix = 1'b1;
        r.pixel_value = {ALPHA, b, bg_hold};
        idx = (32'(height_q) - 32'd1 - 32'(row_q)) * 32'(width_q) + 32'(col_q);
        r.pixel_index = idx[INDEX_W-1:0];
        phase_q = 2'd0;
        col_q   = col_q + 1'b1;
        if (col_q >= width_q) begin
          col_q = '0;
          row_q = row_q + 1'b1;
          pad_q = width_q[1:0];
        end
      end
    end
    last_pos = byte_cnt;
    if (byte_cnt != 32'hffff_ffff) byte_cnt = byte_cnt + 32'd1;
    if (pix || last) begin
      r.pixel_valid = pix;
      if (last) begin
        st = fault_q;
        if (last_pos >= 32'd5 && {32'd0, size_field} != 64'(last_pos) + 64'd1) begin
          if (st == ST_OK || st > ST_SIZE) st = ST_SIZE;
        end
        if (st == ST_OK && (last_pos < HEADER_BYTES - 1 || row_q < height_q)) st = ST_TRUNCATED;
        r.done_res     = 1'b1;
        r.status       = st;
        r.image_width  = width_q;
        r.image_height = height_q;
        clear_decoder();
      end
      decoded_q.push_back(r);
    end
  endfunction

  function automatic void put32(int at, logic [31:0] v);
    for (int k = 0; k < 4; k++) file_bytes[at + k] = v[8*k +: 8];
  endfunction

  function automatic logic [31:0] bad_dim();
    case ($urandom_range(0, 2))
      0:       return 32'd0;
      1:       return 32'h8000_0000 | $urandom;
      default: return $urandom_range(MAX_DIM + 1, 32'h7fff_ffff);
    endcase
  endfunction

  // builds a file in file_bytes; keep < 0 keeps the whole file, else cuts it to at most keep bytes
  task automatic build_file(input logic [31:0] w, input logic [31:0] h, input int gap,
                            input int tail, input int faults, input int keep);
    int rows;
    int final_len;
    bit dims_good;
    file_bytes.delete();
    repeat (HEADER_BYTES) file_bytes.push_back(8'($urandom));
    file_bytes[0] = SIG_B;
    file_bytes[1] = SIG_M;
    put32(OFS_RESV, 32'd0);
    put32(OFS_OFFSET, 32'(HEADER_BYTES + gap));
    put32(OFS_INFOHDR, INFOHDR_SIZE);
    put32(OFS_WIDTH, w);
    put32(OFS_HEIGHT, h);
    file_bytes[OFS_BPP]     = BPP_24[7:0];
    file_bytes[OFS_BPP + 1] = BPP_24[15:8];
    put32(OFS_COMPRESS, 32'd0);
    dims_good = !w[31] && w != 0 && w <= MAX_DIM && !h[31] && h != 0 && h <= MAX_DIM;
    rows = dims_good ? int'(h) : 0;
    repeat (gap) file_bytes.push_back(8'($urandom));
    for (int r = 0; r < rows; r++) begin
      if (keep >= 0 && file_bytes.size() >= keep) break;
      repeat (3 * int'(w) + int'(w[1:0])) file_bytes.push_back(8'($urandom));
    end
    if (!dims_good) repeat ($urandom_range(0, 8)) file_bytes.push_back(8'($urandom));
    if (keep < 0 || file_bytes.size() < keep) repeat (tail) file_bytes.push_back(8'($urandom));
    if (faults[F_SIG]) file_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    if (faults[F_RESV]) file_bytes[$urandom_range(6, 9)] = 8'($urandom_range(1, 255));
    if (faults[F_INFO]) file_bytes[$urandom_range(14, 17)] ^= 8'($urandom_range(1, 255));
    if (faults[F_BPP]) file_bytes[$urandom_range(28, 29)] ^= 8'($urandom_range(1, 255));
    if (faults[F_COMP]) file_bytes[$urandom_range(30, 33)] = 8'($urandom_range(1, 255));
    if (faults[F_OFFSET]) put32(OFS_OFFSET, $urandom_range(0, HEADER_BYTES - 1));
    final_len = (keep >= 0 && keep < file_bytes.size()) ? keep : file_bytes.size();
    put32(OFS_SIZE, faults[F_SIZE] ? 32'(final_len) ^ (32'd1 << $urandom_range(0, 31))
                                   : 32'(final_len));
    while (file_bytes.size() > final_len) void'(file_bytes.pop_back());
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int   gap;
    logic taken;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    decode_byte(b, last);
    n_bytes++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    in_valid <= 1'b0;
    @(posedge clk);
    n_files++;
  endtask

  task automatic wait_for_results();
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_good_images();
    build_file(1, 1, 0, 0, 0, -1);
    send_file();
    build_file(2, 3, 0, 0, 0, -1);
    send_file();
    build_file(3, 2, 3, 0, 0, -1);
    send_file();
    build_file(4, 2, 0, 0, 0, -1);
    send_file();
    build_file(5, 1, 0, 2, 0, -1);
    send_file();
    build_file(7, 2, 1, 0, 0, -1);
    send_file();
    wait_for_results();
  endtask

  task automatic test_header_faults();
    for (int f = F_SIG; f < F_COUNT; f++) begin
      build_file(2, 2, 0, 0, 1 << f, -1);
      send_file();
    end
    // ranking of several faults
    build_file(2, 2, 0, 0, (1 << F_SIG) | (1 << F_BPP), -1);
    send_file();
    build_file(2, 2, 0, 0, (1 << F_SIZE) | (1 << F_OFFSET), -1);
    send_file();
    build_file(2, 2, 0, 0, (1 << F_RESV) | (1 << F_COMP) | (1 << F_INFO), -1);
    send_file();
    build_file(3, 1, 0, 3, 1 << F_SIZE, -1);
    send_file();
    // bad dimensions
    build_file(0, 2, 0, 0, 0, -1);
    send_file();
    build_file(32'h8000_0001, 2, 0, 0, 0, -1);
    send_file();
    build_file(MAX_DIM + 1, 2, 0, 0, 0, -1);
    send_file();
    build_file(2, 0, 0, 0, 0, -1);
    send_file();
    build_file(2, 32'hffff_ffff, 0, 0, 0, -1);
    send_file();
    build_file(32'h7fff_ffff, 1, 0, 0, 1 << F_SIG, -1);
    send_file();
    wait_for_results();
  endtask

  task automatic test_short_files();
    int cut_lens[7] = '{2, 5, 6, 30, 53, 54, 61};
    file_bytes = '{SIG_B};
    send_file();
    file_bytes = '{8'hff};
    send_file();
    foreach (cut_lens[k]) begin
      build_file(2, 2, 0, 0, 0, cut_lens[k]);
      send_file();
    end
    // pixel offset beyond the end of the file
    build_file(1, 1, 200, 0, 0, 100);
    send_file();
    wait_for_results();
  endtask

  task automatic test_max_dims();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    build_file(MAX_DIM, MAX_DIM, 0, 0, 0, HEADER_BYTES + 30);
    send_file();
    build_file(1, MAX_DIM, 0, 0, 0, HEADER_BYTES + 80);
    send_file();
    wait_for_results();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_files();
    int          sent;
    int          kind;
    int          faults;
    int          len;
    logic [31:0] w;
    logic [31:0] h;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      tx_idle_en = $urandom_range(0, 4) != 0;
      rx_idle_en = $urandom_range(0, 4) != 0;
      kind = $urandom_range(0, 9);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if (kind < 7) begin
        build_file(w, h, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 0, -1);
      end else if (kind == 7) begin
        faults = 0;
        case ($urandom_range(0, 2))
          0: begin
            faults = 1 << $urandom_range(F_SIG, F_OFFSET);
            if ($urandom_range(0, 1) != 0) faults |= 1 << $urandom_range(F_SIG, F_OFFSET);
          end
          1: w = bad_dim();
          default: h = bad_dim();
        endcase
        build_file(w, h, 0, 0, faults, -1);
      end else if (kind == 8) begin
        build_file(w, h, 0, 0, 0, $urandom_range(1, HEADER_BYTES + 3 * int'(w * h)));
      end else begin
        // noise, sometimes with a valid signature
        len = $urandom_range(1, 60);
        file_bytes.delete();
        repeat (len) file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) != 0) begin
          file_bytes[0] = SIG_B;
          if (len > 1) file_bytes[1] = SIG_M;
        end
      end
      sent += file_bytes.size();
      send_file();
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  initial begin : result_checker
    result_t seen;
    result_t want;
    logic    got;
    int      n;
    do @(posedge clk); while (rst);
    forever begin
      n = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got                = out_valid;
        seen.pixel_valid   = pixel_valid;
        seen.pixel_value   = pixel_value;
        seen.pixel_index   = pixel_index;
        seen.done_res      = done_res;
        seen.status        = status_t'(status);
        seen.image_width   = image_width;
        seen.image_height  = image_height;
        @(posedge clk);
      end while (got !== 1'b1);
      if (decoded_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none, actual value %0h index %0h",
                   $time, seen.pixel_value, seen.pixel_index);
      end else begin
        want = decoded_q.pop_front();
        compare_field("pixel_valid", want.pixel_valid, seen.pixel_valid);
        compare_field("pixel_value", want.pixel_value, seen.pixel_value);
        compare_field("pixel_index", want.pixel_index, seen.pixel_index);
        compare_field("done_res", want.done_res, seen.done_res);
        compare_field("status", want.status, seen.status);
        compare_field("image_width", want.image_width, seen.image_width);
        compare_field("image_height", want.image_height, seen.image_height);
        if (want.pixel_valid) n_pixels++;
        if (want.done_res) n_done++;
      end
    end
  end

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, decoded_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clear_decoder();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_good_images();
    test_header_faults();
    test_short_files();
    test_max_dims();
    test_random_files();
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("sent %0d files in %0d bytes: good images, header faults, short files,",
             n_files, n_bytes);
    $display("maximum dimensions and random streams; %0d pixels, %0d done checked, %0d errors",
             n_pixels, n_done, fail_cnt);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
